[rtl/core/ptbl_pkg.sv]
// Package for the two-level page table engine: widths, command codes,
// controller states and the captured request type. No dependencies.
package ptbl_pkg;

  // address split: directory index, table index, page offset
  localparam int unsigned ADDR_W      = 32;
  localparam int unsigned IDX_W       = 10;
  localparam int unsigned OFS_W       = 12;
  localparam int unsigned FRAME_W     = ADDR_W - OFS_W;
  localparam int unsigned DIR_ENTRIES = 1 << IDX_W;
  localparam int unsigned DIR_LSB     = 22;
  localparam int unsigned TBL_LSB     = 12;
  localparam int unsigned COUNT_W     = 15;

  // present flag in a page table entry
  localparam logic [OFS_W-1:0] PRESENT_BIT = 12'h001;

  // command codes; the unused code behaves as a translate
  typedef enum logic [1:0] {
    CMD_MAP   = 2'd0,
    CMD_UNMAP = 2'd1,
    CMD_XLATE = 2'd2
  } cmd_e;

  // controller states
  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIR,
    ST_TBL
  } state_e;

  // request held while it walks the tables
  typedef struct packed {
    logic [1:0]        cmd;
    logic [ADDR_W-1:0] virt;
    logic [ADDR_W-1:0] phys;
    logic [OFS_W-1:0]  flags;
  } req_t;

endpackage

[rtl/core/ptbl_req_if.sv]
// Request channel of the page table engine: valid/ready with the command
// payload. Depends on ptbl_pkg for field widths.
interface ptbl_req_if;
  logic                       valid;
  logic                       ready;
  logic [1:0]                 cmd;
  logic [ptbl_pkg::ADDR_W-1:0] vaddr;
  logic [ptbl_pkg::ADDR_W-1:0] phys_addr;
  logic [ptbl_pkg::OFS_W-1:0]  page_flags;

  modport source (output valid, cmd, vaddr, phys_addr, page_flags, input ready);
  modport sink   (input valid, cmd, vaddr, phys_addr, page_flags, output ready);
endinterface

[rtl/core/ptbl_rsp_if.sv]
// Response channel of the page table engine: valid/ready with the result
// payload. Depends on ptbl_pkg for field widths.
interface ptbl_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [ptbl_pkg::ADDR_W-1:0]  phys_out;
  logic                         is_mapped;
  logic                         status;
  logic [ptbl_pkg::COUNT_W-1:0] mapped_count;
  logic                         tlb_invalidate;

  modport source (output valid, phys_out, is_mapped, status, mapped_count, tlb_invalidate,
                  input ready);
  modport sink   (input valid, phys_out, is_mapped, status, mapped_count, tlb_invalidate,
                  output ready);
endinterface

[rtl/core/ptbl_ram.sv]
// Simple dual-port synchronous RAM, one write and one registered read port.
// Holds the page directory and the page table pool. No dependencies.
module ptbl_ram #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = 10,
  parameter int unsigned DW    = 32
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, data held until the next enabled read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/core/two_level_page_table_engine.sv]
// Two-level page table engine: the controller, the directory RAM and the
// page table pool RAM. Depends on ptbl_pkg, ptbl_req_if, ptbl_rsp_if, ptbl_ram.
//
// Usage:
//   req carries one command per transfer: map (cmd 0), unmap (cmd 1) or
//   translate (cmd 2, and the unused code 3), with vaddr, phys_addr and
//   page_flags. rsp returns one result per request: phys_out, is_mapped,
//   status (pool exhausted on map), mapped_count and tlb_invalidate.
//   Each request walks its steps in order: directory RAM read, then the dependent page
//   table RAM read, then the entry write-back together with the response
//   register load. req.ready is high in the cycle the engine waits for work;
//   the result appears on rsp from the response register loaded in the write-back step. One
//   request is in flight at a time: the next is taken only after the write-back.
//   The response sits in an output register: a new request is taken while a
//   result still waits, and the engine holds in its write-back step while
//   rsp stalls with the register full.
//   After reset a clearing pass zeroes the directory and the table pool, one
//   entry per cycle across all NUM_TABLES*1024 entries of the pool (16384 by default), with
//   req.ready low. Tables come from a bump pool and are never freed.
module two_level_page_table_engine #(
  parameter int unsigned NUM_TABLES = 16
) (
  input logic       clk,
  input logic       rst,
  ptbl_req_if.sink  req,
  ptbl_rsp_if.source rsp
);

  import ptbl_pkg::*;

  localparam int unsigned TW        = (NUM_TABLES > 1) ? $clog2(NUM_TABLES) : 1;
  localparam int unsigned NFW       = $clog2(NUM_TABLES + 1);
  localparam int unsigned DW        = TW + 1;
  localparam int unsigned TBL_DEPTH = NUM_TABLES * DIR_ENTRIES;
  localparam int unsigned AW        = TW + IDX_W;
  localparam logic [AW-1:0] CLR_LAST = AW'(TBL_DEPTH - 1);

  // state and registers
  state_e               state, state_next;
  logic [AW-1:0]        clr_cnt;
  req_t                 item;
  logic                 slot_ok;
  logic                 pool_fail;
  logic [AW-1:0]        slot_addr;
  logic [NFW-1:0]       next_free, next_free_next;
  logic [COUNT_W-1:0]   count, count_next;

  logic                 rsp_valid;
  logic [ADDR_W-1:0]    rsp_phys;
  logic                 rsp_mapped;
  logic                 rsp_status;
  logic                 rsp_inval;

  // memory ports
  logic                 dir_we, dir_re;
  logic [IDX_W-1:0]     dir_waddr, dir_raddr;
  logic [DW-1:0]        dir_wdata, dir_rdata;
  logic                 tbl_we, tbl_re;
  logic [AW-1:0]        tbl_waddr, tbl_raddr;
  logic [ADDR_W-1:0]    tbl_wdata, tbl_rdata;

  // controller outputs
  logic                 req_ready;
  logic                 rsp_load;
  logic                 dir_hit, alloc;
  logic [TW-1:0]        tab_sel;
  logic                 present;
  logic [ADDR_W-1:0]    res_phys;
  logic                 res_mapped, res_status, res_inval;

  ptbl_ram #(.DEPTH(DIR_ENTRIES), .AW(IDX_W), .DW(DW)) u_dir_ram (
    .clk   (clk),
    .we    (dir_we),
    .waddr (dir_waddr),
    .wdata (dir_wdata),
    .re    (dir_re),
    .raddr (dir_raddr),
    .rdata (dir_rdata)
  );

  ptbl_ram #(.DEPTH(TBL_DEPTH), .AW(AW), .DW(ADDR_W)) u_tbl_ram (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (tbl_waddr),
    .wdata (tbl_wdata),
    .re    (tbl_re),
    .raddr (tbl_raddr),
    .rdata (tbl_rdata)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: if (clr_cnt == CLR_LAST) state_next = ST_IDLE;
      ST_IDLE:  if (req.valid) state_next = ST_DIR;
      ST_DIR:   state_next = ST_TBL;
      ST_TBL:   if (rsp_load) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // directory lookup and allocation decode
  assign dir_hit = dir_rdata[DW-1];
  assign alloc   = !dir_hit && (item.cmd == CMD_MAP) && (next_free < NFW'(NUM_TABLES));
  assign tab_sel = dir_hit ? dir_rdata[TW-1:0] : next_free[TW-1:0];
  assign present = slot_ok && tbl_rdata[0];

  // per-state outputs
  always_comb begin
    req_ready      = 1'b0;
    rsp_load       = 1'b0;
    dir_we         = 1'b0;
    dir_waddr      = item.virt[DIR_LSB +: IDX_W];
    dir_wdata      = {1'b1, next_free[TW-1:0]};
    dir_re         = 1'b0;
    dir_raddr      = req.vaddr[DIR_LSB +: IDX_W];
    tbl_we         = 1'b0;
    tbl_waddr      = slot_addr;
    tbl_wdata      = '0;
    tbl_re         = 1'b0;
    tbl_raddr      = {tab_sel, item.virt[TBL_LSB +: IDX_W]};
    next_free_next = next_free;
    count_next     = count;
    res_phys       = '0;
    res_mapped     = 1'b0;
    res_status     = 1'b0;
    res_inval      = 1'b0;
    case (state)
      ST_CLEAR: begin
        // sweep both stores, the directory only over its own depth
        tbl_we    = 1'b1;
        tbl_waddr = clr_cnt;
        dir_we    = ({1'b0, clr_cnt} < (AW + 1)'(DIR_ENTRIES));
        dir_waddr = clr_cnt[IDX_W-1:0];
        dir_wdata = '0;
      end
      ST_IDLE: begin
        req_ready = 1'b1;
        dir_re    = req.valid;
      end
      ST_DIR: begin
        // directory data back: claim a table on first map, read the entry
        tbl_re = 1'b1;
        if (alloc) begin
          dir_we         = 1'b1;
          next_free_next = next_free + NFW'(1);
        end
      end
      ST_TBL: begin
        rsp_load = !rsp_valid || rsp.ready;
        case (item.cmd)
          CMD_MAP: begin
            if (slot_ok) begin
              tbl_we     = rsp_load;
              tbl_wdata  = {item.phys[ADDR_W-1:OFS_W], item.flags | PRESENT_BIT};
              res_mapped = 1'b1;
              res_inval  = 1'b1;
              if (!present) count_next = count + COUNT_W'(1);
            end else begin
              res_status = pool_fail;
            end
          end
          CMD_UNMAP: begin
            if (present) begin
              tbl_we     = rsp_load;
              tbl_wdata  = '0;
              res_inval  = 1'b1;
              count_next = count - COUNT_W'(1);
            end
          end
          default: begin
            if (present) begin
              res_mapped = 1'b1;
              res_phys   = {tbl_rdata[ADDR_W-1:OFS_W], item.virt[OFS_W-1:0]};
            end
          end
        endcase
      end
      default: begin
        req_ready = 1'b0;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_cnt   <= '0;
      next_free <= '0;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      next_free <= next_free_next;
      if (state == ST_CLEAR) clr_cnt <= clr_cnt + AW'(1);
      if (rsp_load) begin
        count     <= count_next;
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (req.valid && req_ready) begin
      item.cmd   <= req.cmd;
      item.virt  <= req.vaddr;
      item.phys  <= req.phys_addr;
      item.flags <= req.page_flags;
    end
    if (state == ST_DIR) begin
      slot_ok   <= dir_hit || alloc;
      pool_fail <= !dir_hit && !alloc;
      slot_addr <= tbl_raddr;
    end
    if (rsp_load) begin
      rsp_phys   <= res_phys;
      rsp_mapped <= res_mapped;
      rsp_status <= res_status;
      rsp_inval  <= res_inval;
    end
  end

  assign req.ready          = req_ready;
  assign rsp.valid          = rsp_valid;
  assign rsp.phys_out       = rsp_phys;
  assign rsp.is_mapped      = rsp_mapped;
  assign rsp.status         = rsp_status;
  assign rsp.mapped_count   = count;
  assign rsp.tlb_invalidate = rsp_inval;

  // a transfer always starts the directory step
  a_accept_walk: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready |=> state == ST_DIR)
    else $error("request transfer did not start a table walk");

  // a dropped map never also flags an invalidate
  a_status_inval: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> !(rsp.status && rsp.tlb_invalidate))
    else $error("status and invalidate both set");

  // the page count moves only with a response load
  a_count_stable: assert property (@(posedge clk) disable iff (rst)
    !rsp_load |=> $stable(count))
    else $error("page count changed outside write-back");

  // the bump pool never runs past the number of tables
  a_pool_bound: assert property (@(posedge clk) disable iff (rst)
    next_free <= NFW'(NUM_TABLES))
    else $error("table pool overrun");

  // entry write-back only through a valid directory slot
  a_write_slot: assert property (@(posedge clk) disable iff (rst)
    tbl_we && state == ST_TBL |-> slot_ok)
    else $error("table write without a directory slot");

endmodule
